/* hw/rtl/fsh_pkg.sv */
// ----------------------------------------------------------------------------
// Floyd-Steinberg halftone package
// Shared types and constants for the halftone datapath, its line store and
// its output queue.
// ----------------------------------------------------------------------------
package fsh_pkg;

  localparam int ERR_W        = 20;
  localparam int CFG_W        = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int BANKS        = 2;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [7:0] LEVEL_FULL = 8'hFF;
  localparam logic [7:0] LEVEL_ZERO = 8'h00;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       frame_end;
  } pix_out_t;

endpackage

/* hw/rtl/fsh_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and shows the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module fsh_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/fsh_queue.sv */
// ----------------------------------------------------------------------------
// Halftone output queue
// Small register queue that holds finished pixels until the downstream side
// takes them, so the pipeline never has to stop.
// ----------------------------------------------------------------------------
module fsh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fsh_pkg::pix_out_t  push_data,
  input  logic               pop,
  output logic               head_valid,
  output fsh_pkg::pix_out_t  head_data,
  output logic [$clog2(fsh_pkg::QUEUE_DEPTH + 1)-1:0] count
);

  localparam int PW = (fsh_pkg::QUEUE_DEPTH > 1) ? $clog2(fsh_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(fsh_pkg::QUEUE_DEPTH + 1);

  fsh_pkg::pix_out_t slot_r [fsh_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(fsh_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(fsh_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign count      = count_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CW'(fsh_pkg::QUEUE_DEPTH)))
    else $error("output queue written while full");
`endif

endmodule

/* hw/rtl/floyd_steinberg_halftone.sv */
// ----------------------------------------------------------------------------
// Floyd-Steinberg halftone
// Path: an accepted request passes the sum-stage registers, the diffusion-stage
// registers and the output queue before it can be taken. Throughput: one pixel
// per clock while in_stall is low, set by the right-error loop in the sum stage
// and one line-store write per bank per cycle.
// Reset clears position, errors, valid flags and the fill count at once; the
// line store needs no clearing pass: the fill count marks columns with data.
// ----------------------------------------------------------------------------
module floyd_steinberg_halftone #(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int FRACTION_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fsh_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fsh_pkg::pix_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [fsh_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int ERR_W      = fsh_pkg::ERR_W;
  localparam int XW         = $clog2(MAX_LINE_WIDTH);
  localparam int FW         = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CW         = (XW + 1 > fsh_pkg::WIDTH_REG_W) ? XW + 1 : fsh_pkg::WIDTH_REG_W;
  localparam int HW         = fsh_pkg::HEIGHT_REG_W;
  localparam int BANK_DEPTH = (MAX_LINE_WIDTH + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int GW         = FRACTION_BITS + 9;
  localparam int SW         = ((GW > ERR_W) ? GW : ERR_W) + 3;
  localparam int EXW        = ERR_W + 3;
  localparam int QCW        = $clog2(fsh_pkg::QUEUE_DEPTH + 1);
  localparam int KB         = ((114 << FRACTION_BITS) + 500) / 1000;
  localparam int KG         = ((587 << FRACTION_BITS) + 500) / 1000;
  localparam int KR         = ((299 << FRACTION_BITS) + 500) / 1000;
  localparam int ERR_MAX_I  = (1 << (ERR_W - 1)) - 1;

  localparam logic signed [SW-1:0] ERR_MAX    = SW'(ERR_MAX_I);
  localparam logic signed [SW-1:0] ERR_MIN    = SW'(-ERR_MAX_I - 1);
  localparam logic signed [SW-1:0] THRESHOLD  = SW'(128 << FRACTION_BITS);
  localparam logic signed [SW-1:0] FULL_LEVEL = SW'(255 << FRACTION_BITS);

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SW-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > ERR_MAX) begin
      r = ERR_MAX[ERR_W-1:0];
    end else if (v < ERR_MIN) begin
      r = ERR_MIN[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [fsh_pkg::WIDTH_REG_W-1:0] image_width_r;
  logic [HW-1:0]                   image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= fsh_pkg::WIDTH_RESET;
      image_height_r <= fsh_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (fsh_pkg::cfg_reg_t'(cfg_index))
        fsh_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= cfg_wdata[fsh_pkg::WIDTH_REG_W-1:0];
        end
        fsh_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_wdata[HW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Accept stage: position, edge flags, grey level and line-store read.
  logic            accept;
  logic [XW-1:0]   col_r, col_nxt;
  logic [HW-1:0]   row_r, row_nxt;
  logic [XW-1:0]   x0;
  logic [HW-1:0]   y0;
  logic [CW-1:0]   x0_next;
  logic [HW:0]     y0_next;
  logic            last_col0, last_row0;
  logic [GW-1:0]   grey0;
  logic [BANK_AW-1:0] rd_addr;

  logic                    s1_valid_r;
  logic [XW-1:0]           s1_x_r;
  logic                    s1_last_col_r, s1_last_row_r, s1_fs_r;
  logic [GW-1:0]           s1_grey_r;
  logic [7:0]              s1_alpha_r;

  logic                    s2_valid_r;
  logic [XW-1:0]           s2_x_r;
  logic                    s2_last_col_r, s2_last_row_r, s2_fs_r;
  logic signed [ERR_W-1:0] s2_e_r;
  logic                    s2_level_r;
  logic [7:0]              s2_alpha_r;

  logic [QCW-1:0]          q_count;
  logic [QCW:0]            occupancy;

  assign occupancy = (QCW + 1)'(q_count) + (QCW + 1)'(s1_valid_r) + (QCW + 1)'(s2_valid_r);
  assign in_stall  = (occupancy >= (QCW + 1)'(fsh_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;

  always_comb begin
    x0        = in_data.frame_start ? '0 : col_r;
    y0        = in_data.frame_start ? '0 : row_r;
    x0_next   = CW'(x0) + CW'(1);
    y0_next   = (HW + 1)'(y0) + (HW + 1)'(1);
    last_col0 = (x0_next >= CW'(image_width_r)) || (x0 == XW'(MAX_LINE_WIDTH - 1));
    last_row0 = (y0_next >= (HW + 1)'(image_height_r));
    if (last_col0) begin
      col_nxt = '0;
      row_nxt = last_row0 ? '0 : y0_next[HW-1:0];
    end else begin
      col_nxt = x0 + XW'(1);
      row_nxt = y0;
    end
    grey0   = GW'(KB) * GW'(in_data.blue) + GW'(KG) * GW'(in_data.green)
            + GW'(KR) * GW'(in_data.red);
    rd_addr = BANK_AW'(x0 >> 1);
  end

  // Line store: two banks split by column parity, so that the two writes at
  // the end of a line always land in different banks.
  logic signed [ERR_W-1:0] ram_rdata [fsh_pkg::BANKS];
  logic                    wr_en     [fsh_pkg::BANKS];
  logic [BANK_AW-1:0]      wr_addr   [fsh_pkg::BANKS];
  logic signed [ERR_W-1:0] wr_data   [fsh_pkg::BANKS];
  logic                    pw_en_r   [fsh_pkg::BANKS];
  logic [BANK_AW-1:0]      pw_addr_r [fsh_pkg::BANKS];
  logic signed [ERR_W-1:0] pw_data_r [fsh_pkg::BANKS];

  for (genvar gb = 0; gb < fsh_pkg::BANKS; gb++) begin : g_bank
    fsh_ram #(
      .WIDTH(ERR_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en[gb]),
      .waddr(wr_addr[gb]),
      .wdata(wr_data[gb]),
      .raddr(rd_addr),
      .rdata(ram_rdata[gb])
    );
  end

  // Sum stage: store entry with forwarding, threshold and right error.
  logic [FW-1:0]           fill_r, fill_nxt;
  logic signed [ERR_W-1:0] right_r;
  logic [0:0]              s1_bank;
  logic [BANK_AW-1:0]      s1_addr;
  logic signed [ERR_W-1:0] store_val, right_use, e1, right_nxt;
  logic signed [SW-1:0]    s1_sum, s1_diff, s1_seven;
  logic                    level1;

  always_comb begin
    s1_bank = s1_x_r[0];
    s1_addr = BANK_AW'(s1_x_r >> 1);
    if (s1_fs_r) begin
      store_val = '0;
    end else if (wr_en[s1_bank] && wr_addr[s1_bank] == s1_addr) begin
      store_val = wr_data[s1_bank];
    end else if (pw_en_r[s1_bank] && pw_addr_r[s1_bank] == s1_addr) begin
      store_val = pw_data_r[s1_bank];
    end else if (FW'(s1_x_r) < fill_r && !(s2_valid_r && s2_fs_r)) begin
      store_val = ram_rdata[s1_bank];
    end else begin
      store_val = '0;
    end
    right_use = s1_fs_r ? '0 : right_r;
    s1_sum    = $signed(SW'(s1_grey_r)) + SW'(right_use) + SW'(store_val);
    level1    = (s1_sum >= THRESHOLD);
    s1_diff   = s1_sum - (level1 ? FULL_LEVEL : '0);
    e1        = sat_err(s1_diff);
    s1_seven  = (SW'(e1) <<< 3) - SW'(e1);
    right_nxt = s1_last_col_r ? '0 : sat_err(s1_seven >>> 4);
  end

  // Diffusion stage: below shares, pending sums and line-store writes.
  logic signed [ERR_W-1:0] bl_pending_r, b_pending_r;
  logic signed [ERR_W-1:0] bl_pending_nxt, b_pending_nxt;
  logic signed [ERR_W-1:0] bl_use, b_use, sh_bl, sh_b, sh_br, wa_data, wb_data;
  logic signed [EXW-1:0]   e_x, e_three, e_five;
  logic [XW-1:0]           wa_idx;
  logic                    wa_en, wb_en;
  logic [FW-1:0]           fill_base, fill_cand;

  always_comb begin
    e_x     = EXW'(s2_e_r);
    e_three = (e_x <<< 1) + e_x;
    e_five  = (e_x <<< 2) + e_x;
    sh_bl   = s2_last_row_r ? '0 : ERR_W'(e_three >>> 4);
    sh_b    = s2_last_row_r ? '0 : ERR_W'(e_five >>> 4);
    sh_br   = (s2_last_row_r || s2_last_col_r) ? '0 : ERR_W'(e_x >>> 4);
    bl_use  = s2_fs_r ? '0 : bl_pending_r;
    b_use   = s2_fs_r ? '0 : b_pending_r;
    wa_data = sat_err(SW'(bl_use) + SW'(sh_bl));
    wb_data = sat_err(SW'(b_use) + SW'(sh_b));
    wa_idx  = s2_x_r - XW'(1);
    wa_en   = s2_valid_r && (s2_x_r != '0);
    wb_en   = s2_valid_r && s2_last_col_r;

    for (int j = 0; j < fsh_pkg::BANKS; j++) begin
      if (wa_en && wa_idx[0] == 1'(j)) begin
        wr_en[j]   = 1'b1;
        wr_addr[j] = BANK_AW'(wa_idx >> 1);
        wr_data[j] = wa_data;
      end else if (wb_en && s2_x_r[0] == 1'(j)) begin
        wr_en[j]   = 1'b1;
        wr_addr[j] = BANK_AW'(s2_x_r >> 1);
        wr_data[j] = wb_data;
      end else begin
        wr_en[j]   = 1'b0;
        wr_addr[j] = '0;
        wr_data[j] = '0;
      end
    end

    if (s2_last_col_r) begin
      bl_pending_nxt = '0;
      b_pending_nxt  = '0;
      fill_cand      = FW'(s2_x_r) + FW'(1);
    end else begin
      bl_pending_nxt = wb_data;
      b_pending_nxt  = sh_br;
      fill_cand      = FW'(s2_x_r);
    end
    fill_base = s2_fs_r ? '0 : fill_r;
    fill_nxt  = (fill_cand > fill_base) ? fill_cand : fill_base;
  end

  // Control and error state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      right_r      <= '0;
      bl_pending_r <= '0;
      b_pending_r  <= '0;
      fill_r       <= '0;
      for (int j = 0; j < fsh_pkg::BANKS; j++) begin
        pw_en_r[j] <= 1'b0;
      end
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s1_valid_r) begin
        right_r <= right_nxt;
      end
      if (s2_valid_r) begin
        bl_pending_r <= bl_pending_nxt;
        b_pending_r  <= b_pending_nxt;
        fill_r       <= fill_nxt;
      end
      for (int j = 0; j < fsh_pkg::BANKS; j++) begin
        pw_en_r[j] <= wr_en[j] && !(s1_valid_r && s1_fs_r);
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_x_r        <= x0;
    s1_last_col_r <= last_col0;
    s1_last_row_r <= last_row0;
    s1_fs_r       <= in_data.frame_start;
    s1_grey_r     <= grey0;
    s1_alpha_r    <= in_data.alpha;
    s2_x_r        <= s1_x_r;
    s2_last_col_r <= s1_last_col_r;
    s2_last_row_r <= s1_last_row_r;
    s2_fs_r       <= s1_fs_r;
    s2_e_r        <= e1;
    s2_level_r    <= level1;
    s2_alpha_r    <= s1_alpha_r;
    for (int j = 0; j < fsh_pkg::BANKS; j++) begin
      pw_addr_r[j] <= wr_addr[j];
      pw_data_r[j] <= wr_data[j];
    end
  end

  // Output queue.
  fsh_pkg::pix_out_t push_data;

  always_comb begin
    push_data.out_blue  = s2_level_r ? fsh_pkg::LEVEL_FULL : fsh_pkg::LEVEL_ZERO;
    push_data.out_green = push_data.out_blue;
    push_data.out_red   = push_data.out_blue;
    push_data.out_alpha = s2_alpha_r;
    push_data.frame_end = s2_last_col_r && s2_last_row_r;
  end

  fsh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (push_data),
    .pop       (out_valid && !out_stall),
    .head_valid(out_valid),
    .head_data (out_data),
    .count     (q_count)
  );

`ifndef NO_ASSERTIONS
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (QCW + 1)'(fsh_pkg::QUEUE_DEPTH))
    else $error("more requests in flight than queue slots");

  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_blue == out_data.out_green)
      && (out_data.out_green == out_data.out_red)
      && (out_data.out_blue == fsh_pkg::LEVEL_FULL
          || out_data.out_blue == fsh_pkg::LEVEL_ZERO))
    else $error("colour outputs disagree or are not a halftone level");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_last_col_r) |=> (bl_pending_r == '0) && (b_pending_r == '0))
    else $error("pending below errors not cleared at the end of a line");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_LINE_WIDTH))
    else $error("line store fill count beyond the line store");
`endif

endmodule
